// File: rtl/core/clsr_pkg.sv
// constants, sequencer types and control store for the combined lcg shuffle generator
// no dependencies; used by combined_lcg_shuffle_random_core
package clsr_pkg;

    // request commands
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    // generator constants
    localparam logic [30:0] MOD1        = 31'd2147483563;
    localparam logic [30:0] MOD2        = 31'd2147483399;
    localparam logic [15:0] MUL1        = 16'd40014;
    localparam logic [15:0] MUL2        = 16'd40692;
    // 2^31 - modulus, used to fold the high part of a product
    localparam logic [7:0]  FOLD1       = 8'd85;
    localparam logic [7:0]  FOLD2       = 8'd249;
    localparam logic [31:0] SEED2_RESET = 32'd123456789;
    localparam logic [30:0] TOP_DRAW    = 31'd2147483562;

    // shuffle table size and the extra warm-up steps ahead of the fill
    localparam int TABLE_SIZE_DEF = 32;
    localparam int WARM_EXTRA     = 8;

    // control store addresses
    typedef enum logic [3:0] {
        UPC_IDLE      = 4'd0,
        UPC_SEED_MUL  = 4'd1,
        UPC_SEED_WAIT = 4'd2,
        UPC_SEED_WB   = 4'd3,
        UPC_DRAW_G1   = 4'd4,
        UPC_DRAW_G2   = 4'd5,
        UPC_DRAW_RD   = 4'd6,
        UPC_DRAW_SUB  = 4'd7,
        UPC_DRAW_OUT  = 4'd8
    } t_upc;

    // sequencing kinds
    typedef enum logic [1:0] {
        JMP_ALWAYS    = 2'd0,  // go to target
        JMP_ON_REQ    = 2'd1,  // wait for a request, branch when seeding is needed
        JMP_WHILE_CNT = 2'd2,  // branch while warm-up count is nonzero, else target
        JMP_ON_SLOT   = 2'd3   // go to target once the output register is free
    } t_jump;

    // one control word
    typedef struct packed {
        logic  mul_g2;     // multiplier takes second generator, else first
        logic  wb_x;       // multiplier result into first generator state
        logic  wb_second;  // multiplier result into second generator state
        logic  fill;       // warm-up write into shuffle table
        logic  q_est;      // reciprocal estimate of table index
        logic  q_rem;      // index remainder
        logic  rd_issue;   // table read at corrected index
        logic  draw_done;  // table write back, last draw and output load
        t_jump jump;
        t_upc  target;
        t_upc  branch;
    } t_uword;

    // control store
    function automatic t_uword uc_rom(input t_upc upc);
        t_uword w;
        w        = '0;
        w.jump   = JMP_ALWAYS;
        w.target = UPC_IDLE;
        w.branch = UPC_IDLE;
        unique case (upc)
            UPC_IDLE: begin
                w.jump   = JMP_ON_REQ;
                w.target = UPC_DRAW_G1;
                w.branch = UPC_SEED_MUL;
            end
            UPC_SEED_MUL: begin
                w.target = UPC_SEED_WAIT;
            end
            UPC_SEED_WAIT: begin
                w.target = UPC_SEED_WB;
            end
            UPC_SEED_WB: begin
                w.wb_x   = 1'b1;
                w.fill   = 1'b1;
                w.jump   = JMP_WHILE_CNT;
                w.target = UPC_DRAW_G1;
                w.branch = UPC_SEED_MUL;
            end
            UPC_DRAW_G1: begin
                w.q_est  = 1'b1;
                w.target = UPC_DRAW_G2;
            end
            UPC_DRAW_G2: begin
                w.mul_g2 = 1'b1;
                w.q_rem  = 1'b1;
                w.target = UPC_DRAW_RD;
            end
            UPC_DRAW_RD: begin
                w.wb_x     = 1'b1;
                w.rd_issue = 1'b1;
                w.target   = UPC_DRAW_SUB;
            end
            UPC_DRAW_SUB: begin
                w.wb_second = 1'b1;
                w.target    = UPC_DRAW_OUT;
            end
            UPC_DRAW_OUT: begin
                w.draw_done = 1'b1;
                w.jump      = JMP_ON_SLOT;
                w.target    = UPC_IDLE;
                w.branch    = UPC_DRAW_OUT;
            end
            default: begin
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/combined_lcg_shuffle_random_core.sv
// combined lcg generator with shuffle table, microcoded sequencer and datapath
// depends on clsr_pkg (constants, control store)
//
// Usage:
//   Request channel: i_valid / o_stall with i_command and i_seed_value. Command 0 draws
//   the next number; command 1 loads i_seed_value into the first generator, then draws.
//   A seed of zero or below, or a draw while the first generator holds zero, starts a
//   full seeding: both generators start from max(1, -seed) and TABLE_SIZE+8 warm-up
//   steps fill the shuffle table.
//   Result channel: o_valid / i_stall with o_draw (1..2147483562, uniform value is
//   o_draw / 2147483563) and o_generator_state.
//   Timing: o_valid rises at the end of the five sequencer steps (DRAW_G1 to DRAW_OUT) that
//   follow the accepting idle step; no new request is accepted until the sequencer is idle.
//   Seeding adds TABLE_SIZE+8 warm-up steps of three sequencer steps each: each warm-up step
//   depends on the one before and goes through the three-stage modular multiplier.
//   A finished result sits in the output register; the next request is accepted while
//   it waits. If that result is still stalled when the next one is done, the sequencer
//   holds in its last step and o_stall stays high.
//   Reset: first generator 0, second 123456789, table empty (reads as zero); the first
//   draw after reset without a seed runs a full seeding with 1.
module combined_lcg_shuffle_random_core #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_seed_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_draw,
    output logic [30:0]        o_generator_state
);
    import clsr_pkg::*;

    localparam int AW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int WARM  = TABLE_SIZE + WARM_EXTRA;
    localparam int JW    = $clog2(WARM);
    localparam int RW    = AW + 2;
    localparam logic [30:0]   BUCKET = 31'(1 + TOP_DRAW / TABLE_SIZE);
    localparam logic [RW-1:0] RECIP  = RW'((64'd1 << 31) / BUCKET);

    // sequencer
    t_upc   r_upc, n_upc;
    t_uword uw;

    // generator and draw state
    logic [31:0] r_x;        // first generator, 32 bits for the magnitude of the most negative seed
    logic [31:0] r_second;
    logic [30:0] r_last;
    logic [JW-1:0] r_j;

    // modular multiplier pipeline
    logic [47:0] r_p;
    logic        r_p_g2;
    logic [31:0] r_f;
    logic        r_f_g2;

    // index and table read
    logic [AW-1:0] r_qest;
    logic [31:0]   r_rem;
    logic [AW-1:0] r_idx;
    logic [30:0]   r_rdata;
    logic          r_ent_ok;

    // shuffle table and its valid bits
    logic [30:0]           mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_tvalid;

    // output register
    logic        r_out_valid;
    logic [30:0] r_out_draw;
    logic [30:0] r_out_state;

    logic               accept;
    logic               slot_free;
    logic signed [31:0] work;
    logic               nonpos;
    logic [31:0]        mag;
    logic [31:0]        op_a;
    logic [15:0]        op_k;
    logic [47:0]        prod;
    logic [7:0]         fold_p;
    logic [24:0]        hi_k;
    logic [31:0]        fold_v;
    logic [7:0]         fold_f;
    logic [31:0]        red_v;
    logic [30:0]        mod_f;
    logic [30:0]        res;
    logic [RW+30:0]     q_prod;
    logic [AW+30:0]     qb;
    logic [AW:0]        q_inc;
    logic [AW-1:0]      idx_n;
    logic [30:0]        entry;
    logic [31:0]        d_pos;
    logic [31:0]        d_neg;
    logic [30:0]        draw;
    logic               fill_we;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [30:0]        mem_wdata;

    assign uw        = uc_rom(r_upc);
    assign o_stall   = (r_upc != UPC_IDLE);
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;

    // working value of the first generator and seeding decision
    assign work   = (i_command == CMD_SEED) ? i_seed_value : signed'({1'b0, r_x[30:0]});
    assign nonpos = work[31] || (work == 32'sd0);
    assign mag    = (work == 32'sd0) ? 32'd1 : 32'(-work);

    // next step
    always_comb begin
        n_upc = r_upc;
        unique case (uw.jump)
            JMP_ALWAYS: begin
                n_upc = uw.target;
            end
            JMP_ON_REQ: begin
                if (accept) begin
                    n_upc = nonpos ? uw.branch : uw.target;
                end
            end
            JMP_WHILE_CNT: begin
                n_upc = (r_j != '0) ? uw.branch : uw.target;
            end
            JMP_ON_SLOT: begin
                n_upc = slot_free ? uw.target : uw.branch;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // multiplier stage: operand times generator multiplier
    assign op_a = uw.mul_g2 ? r_second : r_x;
    assign op_k = uw.mul_g2 ? MUL2 : MUL1;
    assign prod = op_a * op_k;

    // first fold: high part times (2^31 - modulus) added to low part
    assign fold_p = r_p_g2 ? FOLD2 : FOLD1;
    assign hi_k   = r_p[47:31] * fold_p;
    assign fold_v = {1'b0, r_p[30:0]} + {7'd0, hi_k};

    // second fold and final subtract
    assign fold_f = r_f_g2 ? FOLD2 : FOLD1;
    assign mod_f  = r_f_g2 ? MOD2 : MOD1;
    assign red_v  = {1'b0, r_f[30:0]} + (r_f[31] ? {24'd0, fold_f} : 32'd0);
    assign res    = (red_v >= {1'b0, mod_f}) ? 31'(red_v - {1'b0, mod_f}) : red_v[30:0];

    always_ff @(posedge i_clk) begin
        r_p    <= prod;
        r_p_g2 <= uw.mul_g2;
        r_f    <= fold_v;
        r_f_g2 <= r_p_g2;
    end

    // table index: reciprocal estimate, remainder, one correction
    assign q_prod = r_last * RECIP;
    assign qb     = r_qest * BUCKET;
    assign q_inc  = {1'b0, r_qest} + (AW+1)'(r_rem >= {1'b0, BUCKET});
    assign idx_n  = (q_inc >= (AW+1)'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : q_inc[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (uw.q_est) begin
            r_qest <= q_prod[31 +: AW];
        end
        if (uw.q_rem) begin
            r_rem <= {1'b0, r_last} - {1'b0, qb[30:0]};
        end
    end

    // draw from table entry and second generator
    assign entry = r_ent_ok ? r_rdata : 31'd0;
    assign d_pos = {1'b0, entry} - r_second;
    assign d_neg = {1'b0, TOP_DRAW} - (r_second - {1'b0, entry});
    assign draw  = ({1'b0, entry} > r_second) ? d_pos[30:0] : d_neg[30:0];

    // table write port: warm-up fill or draw write back
    assign fill_we   = uw.fill && (32'(r_j) < TABLE_SIZE);
    assign mem_we    = fill_we || (uw.draw_done && slot_free);
    assign mem_waddr = fill_we ? r_j[AW-1:0] : r_idx;
    assign mem_wdata = fill_we ? res : r_x[30:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (uw.rd_issue) begin
            r_rdata <= mem[idx_n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else if (mem_we) begin
            r_tvalid[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.rd_issue) begin
            r_idx    <= idx_n;
            r_ent_ok <= r_tvalid[idx_n];
        end
    end

    // generator state, warm-up counter and last draw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_second <= SEED2_RESET;
            r_last   <= '0;
            r_j      <= '0;
        end else begin
            if (accept) begin
                r_x <= nonpos ? mag : 32'(work);
                r_j <= JW'(WARM - 1);
                if (nonpos) begin
                    r_second <= mag;
                end
            end
            if (uw.wb_x) begin
                r_x <= {1'b0, res};
            end
            if (uw.wb_second) begin
                r_second <= {1'b0, res};
            end
            if (uw.fill) begin
                if (r_j == '0) begin
                    r_last <= res;
                end else begin
                    r_j <= r_j - 1'b1;
                end
            end
            if (uw.draw_done && slot_free) begin
                r_last <= draw;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.draw_done && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.draw_done && slot_free) begin
            r_out_draw  <= draw;
            r_out_state <= r_x[30:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_draw            = r_out_draw;
    assign o_generator_state = r_out_state;

    // draws stay inside the generator range
    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_draw != 31'd0) && (o_draw <= TOP_DRAW))
        else $error("draw out of range");

    // first generator state stays below its modulus
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_generator_state < MOD1))
        else $error("generator state not reduced");

    // reciprocal estimate is off by at most one bucket
    a_idx_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_DRAW_RD) |-> (r_rem < {BUCKET, 1'b0}))
        else $error("index remainder beyond one correction");

    // a seeding request starts the warm-up loop with a full count
    a_seed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && nonpos) |=> (r_upc == UPC_SEED_MUL) && (r_j == JW'(WARM - 1)))
        else $error("seeding did not start");

    // a finished draw lands in the output register and frees the request side
    a_draw_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_DRAW_OUT && slot_free) |=> o_valid && (r_upc == UPC_IDLE))
        else $error("finished draw not delivered");

endmodule
